[sv/scba_pkg.sv]
// Types, constants and helper functions of the size-class block allocator.
// Used by the channel interfaces and by the allocator core; depends on nothing.
package scba_pkg;

    localparam int PAGE_BYTES     = 4096;
    localparam int MAX_PAGES      = 64;
    localparam int MIN_CLASS_LOG2 = 3;
    localparam int MAX_CLASS_LOG2 = 11;

    localparam int PAGE_LOG2      = $clog2(PAGE_BYTES);
    localparam int NCLASS         = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
    localparam int CIDX_W         = (NCLASS > 1) ? $clog2(NCLASS) : 1;
    localparam int CLS_W          = $clog2(NCLASS + 1);
    localparam int SLOTS_PER_PAGE = PAGE_BYTES >> MIN_CLASS_LOG2;
    localparam int SOFS_W         = PAGE_LOG2 - MIN_CLASS_LOG2;
    localparam int PAGE_W         = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SLOT_W         = PAGE_W + SOFS_W;
    localparam int SLOTS          = MAX_PAGES * SLOTS_PER_PAGE;
    localparam int LINK_W         = SLOT_W + 1;
    localparam int CNT_W          = $clog2(SLOTS_PER_PAGE + 1);
    localparam int NPG_W          = $clog2(MAX_PAGES + 1);

    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 12;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 3;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int OPG_W   = ADDR_W - PAGE_LOG2;

    // empty list marker, one past the last slot
    localparam logic [LINK_W-1:0] NIL = {1'b1, {SLOT_W{1'b0}}};

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_END  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_NULL    = 3'd1,
        STAT_NOMEM   = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_RANGE   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PAGE_RD,
        ST_PAGE_CHK,
        ST_LINK_CHK,
        ST_PUSH_PREV,
        ST_REL_RD,
        ST_REL_WR,
        ST_REL_END,
        ST_SPLIT,
        ST_SPLIT_END,
        ST_POP_RD,
        ST_POP_WR,
        ST_OUT,
        ST_CFG
    } t_state;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [CNT_W-1:0] cnt;
    } t_pinfo;

    typedef struct packed {
        logic              free;
        logic [LINK_W-1:0] link;
    } t_link;

    // smallest class index whose block holds size bytes
    function automatic logic [CIDX_W-1:0] size_class(input logic [SIZE_W-1:0] size);
        logic [CIDX_W-1:0] c;
        c = '0;
        for (int k = NCLASS - 1; k >= 0; k--) begin
            if (32'(size) <= (32'd1 << (k + MIN_CLASS_LOG2))) begin
                c = CIDX_W'(k);
            end
        end
        return c;
    endfunction

    function automatic logic [SIZE_W-1:0] idx_bytes(input logic [CIDX_W-1:0] c);
        return SIZE_W'(32'd1 << (32'(c) + MIN_CLASS_LOG2));
    endfunction

    // page class code (index + 1, zero when unassigned) to bytes
    function automatic logic [SIZE_W-1:0] code_bytes(input logic [CLS_W-1:0] cls);
        logic [SIZE_W-1:0] r;
        r = '0;
        if (cls != '0) begin
            r = SIZE_W'(32'd1 << (32'(cls) - 1 + MIN_CLASS_LOG2));
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] blocks_of(input logic [CIDX_W-1:0] c);
        return CNT_W'(SLOTS_PER_PAGE >> c);
    endfunction

    function automatic logic [PAGE_LOG2-1:0] align_mask(input logic [CIDX_W-1:0] c);
        return PAGE_LOG2'((32'd1 << (32'(c) + MIN_CLASS_LOG2)) - 1);
    endfunction

endpackage

[sv/scba_req_if.sv]
// Request channel of the allocator: valid/ready handshake with command payload.
// Depends on scba_pkg for field widths.
interface scba_req_if;
    import scba_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, output cmd, output req_size, output block_addr, input ready);
    modport sink   (input valid, input cmd, input req_size, input block_addr, output ready);
endinterface

[sv/scba_rsp_if.sv]
// Result channel of the allocator: valid/ready handshake with result payload.
// Depends on scba_pkg for field widths.
interface scba_rsp_if;
    import scba_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] class_bytes;

    modport source (output valid, output result_addr, output status, output class_bytes,
                    input ready);
    modport sink   (input valid, input result_addr, input status, input class_bytes,
                    output ready);
endinterface

[sv/scba_ram.sv]
// Generic simple dual-port RAM: one write and one registered read per cycle.
// Self-contained; read data shows the contents before a same-cycle write.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

[sv/size_class_block_allocator_core.sv]
// Size-class block allocator core. An allocation pops a list head: its own class, else a page
// split onto that list, else a larger class. A query reads the page table; a free checks page and
// link, pushes the block and, once the whole page is free, unlinks its blocks and returns the page.
// One item at a time: the next item is taken the cycle after the result is loaded.
// Link, page and free-page memories each allow one read and one write per cycle, which sets the walks.
// Reset is synchronous, active low: zero-page heap; a register write reinitializes the heap.
module size_class_block_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scba_req_if.sink                      i_req,
    scba_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scba_pkg::PADDR_W-1:0]  paddr,
    input  logic [scba_pkg::DATA_W-1:0]   pwdata,
    output logic [scba_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import scba_pkg::*;

    t_state r_state, n_state;

    // control state
    logic [ADDR_W-1:0] r_heap_base, n_heap_base;
    logic [ADDR_W-1:0] r_heap_end, n_heap_end;
    logic [NPG_W-1:0]  r_npages, n_npages;
    logic [PAGE_W-1:0] r_fifo_head, n_fifo_head;
    logic [NPG_W-1:0]  r_fifo_count, n_fifo_count;
    logic [MAX_PAGES-1:0] r_pvld, n_pvld;
    logic [MAX_PAGES-1:0] r_fvld, n_fvld;
    logic [LINK_W-1:0] r_head [NCLASS];
    logic [LINK_W-1:0] n_head [NCLASS];
    logic [LINK_W-1:0] r_tail [NCLASS];
    logic [LINK_W-1:0] n_tail [NCLASS];
    logic              r_o_valid, n_o_valid;

    // item payload and working registers
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [ADDR_W-1:0] r_off, n_off;
    logic              r_in_heap, n_in_heap;
    logic [CIDX_W-1:0] r_cls, n_cls;
    logic [SLOT_W-1:0] r_blk, n_blk;
    logic [PAGE_W-1:0] r_pg, n_pg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [LINK_W-1:0] r_h, n_h;
    logic              r_pv, n_pv;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [SIZE_W-1:0] r_res_size, n_res_size;
    logic [ADDR_W-1:0] r_o_addr, n_o_addr;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [SIZE_W-1:0] r_o_size, n_o_size;

    // memory ports
    logic              nx_we;
    logic [SLOT_W-1:0] nx_waddr;
    t_link             nx_wdata, nx_rd;
    logic              pr_we;
    logic [SLOT_W-1:0] pr_waddr;
    logic [LINK_W-1:0] pr_wdata, pr_rd;
    logic [SLOT_W-1:0] lk_raddr;
    logic              pg_we;
    logic [PAGE_W-1:0] pg_waddr, pg_raddr;
    t_pinfo            pg_wdata, pg_rd;
    logic              ff_we;
    logic [PAGE_W-1:0] ff_waddr;
    logic [PAGE_W-1:0] ff_wdata, ff_rd;

    // decisions
    logic              req_acc, cfg_we, out_free;
    logic [ADDR_W-1:0] req_off, cfg_diff;
    logic              req_in_heap;
    logic [NPG_W-1:0]  cfg_npages;
    logic [CIDX_W-1:0] c_dec, found_k;
    logic              found_any, size_zero, size_big, head_hit, can_split;
    logic [PAGE_W-1:0] fifo_pg, push_idx;
    logic [CLS_W-1:0]  cur_cls;
    logic [CNT_W-1:0]  cur_cnt, blocks_c;
    logic              chk_bad, rel_go, idx_last;
    logic [SLOT_W-1:0] slot_i, off_slot;
    logic [PAGE_W-1:0] off_pg, blk_pg;

    scba_ram #(.WIDTH(LINK_W + 1), .DEPTH(SLOTS)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(lk_raddr), .o_rdata(nx_rd)
    );
    scba_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(lk_raddr), .o_rdata(pr_rd)
    );
    scba_ram #(.WIDTH(CLS_W + CNT_W), .DEPTH(MAX_PAGES)) u_page_ram (
        .i_clk(i_clk), .i_we(pg_we), .i_waddr(pg_waddr), .i_wdata(pg_wdata),
        .i_raddr(pg_raddr), .o_rdata(pg_rd)
    );
    scba_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_fifo_ram (
        .i_clk(i_clk), .i_we(ff_we), .i_waddr(ff_waddr), .i_wdata(ff_wdata),
        .i_raddr(r_fifo_head), .o_rdata(ff_rd)
    );

    assign req_acc  = i_req.valid && i_req.ready;
    assign cfg_we   = psel && penable && pwrite;
    assign out_free = !r_o_valid || o_rsp.ready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HEAP_END) ? r_heap_end : r_heap_base;

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.result_addr = r_o_addr;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.class_bytes = r_o_size;

    assign req_off     = i_req.block_addr - r_heap_base;
    assign req_in_heap = (i_req.block_addr >= r_heap_base) &&
                         (req_off[ADDR_W-1:PAGE_LOG2] < OPG_W'(r_npages));

    assign cfg_diff   = r_heap_end - r_heap_base;
    assign cfg_npages = (r_heap_end <= r_heap_base) ? '0 :
                        (cfg_diff[ADDR_W-1:PAGE_LOG2] > OPG_W'(MAX_PAGES)) ? NPG_W'(MAX_PAGES) :
                        NPG_W'(cfg_diff[ADDR_W-1:PAGE_LOG2]);

    assign size_zero = (r_size == '0);
    assign size_big  = (32'(r_size) > (32'd1 << MAX_CLASS_LOG2));
    assign c_dec     = size_class(r_size);
    assign head_hit  = (r_head[c_dec] != NIL);
    assign can_split = (r_fifo_count != '0) && (blocks_of(c_dec) != '0);
    // a free-page entry never written stands for the page of its own index
    assign fifo_pg   = r_fvld[r_fifo_head] ? ff_rd : r_fifo_head;
    assign push_idx  = r_fifo_head + r_fifo_count[PAGE_W-1:0];

    assign cur_cls  = r_pv ? pg_rd.cls : '0;
    assign cur_cnt  = r_pv ? pg_rd.cnt : '0;
    assign blocks_c = blocks_of(r_cls);
    assign off_pg   = r_off[PAGE_LOG2 +: PAGE_W];
    assign off_slot = r_off[MIN_CLASS_LOG2 +: SLOT_W];
    assign blk_pg   = r_blk[SLOT_W-1 -: PAGE_W];
    assign slot_i   = {r_pg, SOFS_W'(r_idx) << r_cls};
    assign chk_bad  = (cur_cls == '0) ||
                      ((r_off[PAGE_LOG2-1:0] & align_mask(CIDX_W'(cur_cls - 1'b1))) != '0);
    assign rel_go   = ((r_cnt + CNT_W'(1)) == blocks_c);
    assign idx_last = ((r_idx + CNT_W'(1)) == blocks_c);

    // first larger class with a nonempty list
    always_comb begin
        found_any = 1'b0;
        found_k   = '0;
        for (int k = NCLASS - 1; k >= 0; k--) begin
            if (CIDX_W'(k) > c_dec && r_head[k] != NIL) begin
                found_any = 1'b1;
                found_k   = CIDX_W'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (size_zero || size_big) n_state = ST_OUT;
                        else if (head_hit)         n_state = ST_POP_RD;
                        else if (can_split)        n_state = ST_SPLIT;
                        else if (found_any)        n_state = ST_POP_RD;
                        else                       n_state = ST_OUT;
                    end
                    CMD_FREE, CMD_QUERY: begin
                        n_state = r_in_heap ? ST_PAGE_RD : ST_OUT;
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_PAGE_RD:  n_state = ST_PAGE_CHK;
            ST_PAGE_CHK: begin
                if (r_cmd == CMD_QUERY || chk_bad) n_state = ST_OUT;
                else                               n_state = ST_LINK_CHK;
            end
            ST_LINK_CHK:  n_state = nx_rd.free ? ST_OUT : ST_PUSH_PREV;
            ST_PUSH_PREV: n_state = rel_go ? ST_REL_RD : ST_OUT;
            ST_REL_RD:    n_state = ST_REL_WR;
            ST_REL_WR:    n_state = idx_last ? ST_REL_END : ST_REL_RD;
            ST_REL_END:   n_state = ST_OUT;
            ST_SPLIT:     n_state = idx_last ? ST_SPLIT_END : ST_SPLIT;
            ST_SPLIT_END: n_state = ST_POP_RD;
            ST_POP_RD:    n_state = ST_POP_WR;
            ST_POP_WR:    n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_CFG:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (cfg_we) n_state = ST_CFG;
    end

    always_comb begin
        n_heap_base  = r_heap_base;
        n_heap_end   = r_heap_end;
        n_npages     = r_npages;
        n_fifo_head  = r_fifo_head;
        n_fifo_count = r_fifo_count;
        n_pvld       = r_pvld;
        n_fvld       = r_fvld;
        n_head       = r_head;
        n_tail       = r_tail;
        n_o_valid    = r_o_valid;
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_off        = r_off;
        n_in_heap    = r_in_heap;
        n_cls        = r_cls;
        n_blk        = r_blk;
        n_pg         = r_pg;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_h          = r_h;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_size   = r_res_size;
        n_o_addr     = r_o_addr;
        n_o_status   = r_o_status;
        n_o_size     = r_o_size;
        nx_we        = 1'b0;
        nx_waddr     = r_blk;
        nx_wdata     = '0;
        pr_we        = 1'b0;
        pr_waddr     = r_blk;
        pr_wdata     = NIL;
        lk_raddr     = r_blk;
        pg_we        = 1'b0;
        pg_waddr     = r_pg;
        pg_wdata     = '0;
        pg_raddr     = r_pg;
        ff_we        = 1'b0;
        ff_waddr     = push_idx;
        ff_wdata     = r_pg;

        if (r_o_valid && o_rsp.ready) n_o_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_cmd     = i_req.cmd;
                    n_size    = i_req.req_size;
                    n_off     = req_off;
                    n_in_heap = req_in_heap;
                end
            end
            ST_DECODE: begin
                n_res_addr   = '0;
                n_res_size   = '0;
                n_res_status = STAT_RANGE;
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (size_zero) begin
                            n_res_status = STAT_NULL;
                        end else if (size_big) begin
                            n_res_status = STAT_RANGE;
                        end else if (head_hit) begin
                            n_blk = r_head[c_dec][SLOT_W-1:0];
                            n_cls = c_dec;
                        end else if (can_split) begin
                            n_pg         = fifo_pg;
                            n_fifo_head  = r_fifo_head + PAGE_W'(1);
                            n_fifo_count = r_fifo_count - NPG_W'(1);
                            n_idx        = '0;
                            n_cls        = c_dec;
                        end else if (found_any) begin
                            n_blk = r_head[found_k][SLOT_W-1:0];
                            n_cls = found_k;
                        end else begin
                            n_res_status = STAT_NOMEM;
                        end
                    end
                    CMD_FREE, CMD_QUERY: begin
                        n_pg = off_pg;
                    end
                    default: begin
                        n_res_status = STAT_RANGE;
                    end
                endcase
            end
            ST_PAGE_CHK: begin
                lk_raddr   = off_slot;
                n_res_addr = '0;
                n_res_size = '0;
                if (r_cmd == CMD_QUERY) begin
                    n_res_status = STAT_OK;
                    n_res_size   = code_bytes(cur_cls);
                end else if (chk_bad) begin
                    n_res_status = STAT_IGNORED;
                end else begin
                    n_cls = CIDX_W'(cur_cls - 1'b1);
                    n_cnt = cur_cnt;
                    n_blk = off_slot;
                end
            end
            ST_LINK_CHK: begin
                if (nx_rd.free) begin
                    // double free
                    n_res_status = STAT_IGNORED;
                end else begin
                    nx_we         = 1'b1;
                    nx_waddr      = r_blk;
                    nx_wdata.free = 1'b1;
                    nx_wdata.link = r_head[r_cls];
                    pr_we         = 1'b1;
                    pr_waddr      = r_blk;
                    pr_wdata      = NIL;
                    n_h           = r_head[r_cls];
                    n_head[r_cls] = {1'b0, r_blk};
                    if (r_head[r_cls] == NIL) n_tail[r_cls] = {1'b0, r_blk};
                end
            end
            ST_PUSH_PREV: begin
                if (r_h != NIL) begin
                    pr_we    = 1'b1;
                    pr_waddr = r_h[SLOT_W-1:0];
                    pr_wdata = {1'b0, r_blk};
                end
                if (rel_go) begin
                    n_idx = '0;
                end else begin
                    pg_we        = 1'b1;
                    pg_waddr     = r_pg;
                    pg_wdata.cls = CLS_W'(r_cls) + CLS_W'(1);
                    pg_wdata.cnt = r_cnt + CNT_W'(1);
                    n_res_status = STAT_OK;
                    n_res_size   = idx_bytes(r_cls);
                end
            end
            ST_REL_RD: begin
                lk_raddr = slot_i;
            end
            ST_REL_WR: begin
                // unlink: every block of the page is on the list here
                if (pr_rd != NIL) begin
                    nx_we         = 1'b1;
                    nx_waddr      = pr_rd[SLOT_W-1:0];
                    nx_wdata.free = 1'b1;
                    nx_wdata.link = nx_rd.link;
                end else begin
                    n_head[r_cls] = nx_rd.link;
                end
                if (nx_rd.link != NIL) begin
                    pr_we    = 1'b1;
                    pr_waddr = nx_rd.link[SLOT_W-1:0];
                    pr_wdata = pr_rd;
                end else begin
                    n_tail[r_cls] = pr_rd;
                end
                n_idx = r_idx + CNT_W'(1);
            end
            ST_REL_END: begin
                if (r_fifo_count < NPG_W'(MAX_PAGES)) begin
                    ff_we            = 1'b1;
                    ff_waddr         = push_idx;
                    ff_wdata         = r_pg;
                    n_fvld[push_idx] = 1'b1;
                    n_fifo_count     = r_fifo_count + NPG_W'(1);
                end
                n_pvld[r_pg] = 1'b0;
                n_res_status = STAT_OK;
                n_res_size   = idx_bytes(r_cls);
            end
            ST_SPLIT: begin
                // append block idx to the tail; its own next link is set by the following block
                if (r_tail[r_cls] != NIL) begin
                    nx_we         = 1'b1;
                    nx_waddr      = r_tail[r_cls][SLOT_W-1:0];
                    nx_wdata.free = 1'b1;
                    nx_wdata.link = {1'b0, slot_i};
                end else begin
                    n_head[r_cls] = {1'b0, slot_i};
                end
                pr_we         = 1'b1;
                pr_waddr      = slot_i;
                pr_wdata      = r_tail[r_cls];
                n_tail[r_cls] = {1'b0, slot_i};
                n_idx         = r_idx + CNT_W'(1);
            end
            ST_SPLIT_END: begin
                nx_we         = 1'b1;
                nx_waddr      = r_tail[r_cls][SLOT_W-1:0];
                nx_wdata.free = 1'b1;
                nx_wdata.link = NIL;
                pg_we         = 1'b1;
                pg_waddr      = r_pg;
                pg_wdata.cls  = CLS_W'(r_cls) + CLS_W'(1);
                pg_wdata.cnt  = blocks_c;
                n_pvld[r_pg]  = 1'b1;
                n_blk         = r_head[r_cls][SLOT_W-1:0];
            end
            ST_POP_RD: begin
                lk_raddr = r_blk;
                pg_raddr = blk_pg;
            end
            ST_POP_WR: begin
                nx_we         = 1'b1;
                nx_waddr      = r_blk;
                nx_wdata.free = 1'b0;
                nx_wdata.link = nx_rd.link;
                n_head[r_cls] = nx_rd.link;
                if (nx_rd.link != NIL) begin
                    pr_we    = 1'b1;
                    pr_waddr = nx_rd.link[SLOT_W-1:0];
                    pr_wdata = NIL;
                end else begin
                    n_tail[r_cls] = NIL;
                end
                if (r_pv && pg_rd.cnt != '0) begin
                    pg_we        = 1'b1;
                    pg_waddr     = blk_pg;
                    pg_wdata.cls = pg_rd.cls;
                    pg_wdata.cnt = pg_rd.cnt - CNT_W'(1);
                end
                n_res_addr   = r_heap_base + ADDR_W'({r_blk, {MIN_CLASS_LOG2{1'b0}}});
                n_res_status = STAT_OK;
                n_res_size   = code_bytes(cur_cls);
            end
            ST_OUT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_status = r_res_status;
                    n_o_size   = r_res_size;
                end
            end
            ST_CFG: begin
                n_npages     = cfg_npages;
                n_fifo_head  = '0;
                n_fifo_count = cfg_npages;
                n_pvld       = '0;
                n_fvld       = '0;
                for (int k = 0; k < NCLASS; k++) begin
                    n_head[k] = NIL;
                    n_tail[k] = NIL;
                end
            end
            default: begin
            end
        endcase

        if (cfg_we) begin
            if (paddr[2] == REG_HEAP_BASE) n_heap_base = pwdata;
            else                           n_heap_end  = pwdata;
        end

        n_pv = r_pvld[pg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_heap_base  <= '0;
            r_heap_end   <= '0;
            r_npages     <= '0;
            r_fifo_head  <= '0;
            r_fifo_count <= '0;
            r_pvld       <= '0;
            r_fvld       <= '0;
            r_o_valid    <= 1'b0;
            for (int k = 0; k < NCLASS; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
            end
        end else begin
            r_state      <= n_state;
            r_heap_base  <= n_heap_base;
            r_heap_end   <= n_heap_end;
            r_npages     <= n_npages;
            r_fifo_head  <= n_fifo_head;
            r_fifo_count <= n_fifo_count;
            r_pvld       <= n_pvld;
            r_fvld       <= n_fvld;
            r_o_valid    <= n_o_valid;
            r_head       <= n_head;
            r_tail       <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_off        <= n_off;
        r_in_heap    <= n_in_heap;
        r_cls        <= n_cls;
        r_blk        <= n_blk;
        r_pg         <= n_pg;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_h          <= n_h;
        r_pv         <= n_pv;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_size   <= n_res_size;
        r_o_addr     <= n_o_addr;
        r_o_status   <= n_o_status;
        r_o_size     <= n_o_size;
    end
endmodule

[verif/size_class_block_allocator_core_tb.sv]
// Testbench of the size-class block allocator core: directed and random allocate, free
// and query items over several heap settings, checked against a built-in allocator model.
// Depends on scba_pkg, scba_req_if, scba_rsp_if and size_class_block_allocator_core.
module size_class_block_allocator_core_tb;
    import scba_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_BAD    = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_BASE  = PADDR_W'(4 * REG_HEAP_BASE);
    localparam logic [PADDR_W-1:0] ADDR_END   = PADDR_W'(4 * REG_HEAP_END);

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] bsize;
    } t_outcome;

    // allocator model: page/list state, expected outcomes and the blocks held by the bench
    class alloc_scoreboard;
        logic [31:0]       base, hend;
        int unsigned       npages;
        int unsigned       pg_cls [MAX_PAGES];
        int unsigned       pg_cnt [MAX_PAGES];
        int unsigned       pg_fifo[MAX_PAGES];
        int unsigned       fifo_head, fifo_cnt;
        int unsigned       nxt[SLOTS];
        int unsigned       prv[SLOTS];
        bit                on_list[SLOTS];
        int unsigned       chead[NCLASS];
        int unsigned       ctail[NCLASS];
        t_outcome          pending_q[$];
        logic [ADDR_W-1:0] held[$];
        logic [ADDR_W-1:0] released[$];
        int                errors, results, splits, releases;

        function void reinit();
            npages = 0;
            if (hend > base) begin
                npages = (hend - base) / PAGE_BYTES;
                if (npages > MAX_PAGES) npages = MAX_PAGES;
            end
            for (int i = 0; i < MAX_PAGES; i++) begin
                pg_cls[i] = 0;
                pg_cnt[i] = 0;
                pg_fifo[i] = i;
            end
            for (int i = 0; i < SLOTS; i++) on_list[i] = 0;
            fifo_head = 0;
            fifo_cnt = npages;
            for (int i = 0; i < NCLASS; i++) begin
                chead[i] = SLOTS;
                ctail[i] = SLOTS;
            end
            held.delete();
            released.delete();
        endfunction

        function void write_reg(logic [PADDR_W-1:0] a, logic [31:0] v);
            if (a == ADDR_BASE) base = v;
            else hend = v;
            reinit();
        endfunction

        function void append_block(int unsigned c, int unsigned b);
            nxt[b] = SLOTS;
            prv[b] = ctail[c];
            if (ctail[c] < SLOTS) nxt[ctail[c]] = b;
            else chead[c] = b;
            ctail[c] = b;
            on_list[b] = 1;
        endfunction

        function void prepend_block(int unsigned c, int unsigned b);
            prv[b] = SLOTS;
            nxt[b] = chead[c];
            if (chead[c] < SLOTS) prv[chead[c]] = b;
            else ctail[c] = b;
            chead[c] = b;
            on_list[b] = 1;
        endfunction

        function void remove_block(int unsigned c, int unsigned b);
            int unsigned p, n;
            p = prv[b];
            n = nxt[b];
            if (p < SLOTS) nxt[p] = n; else chead[c] = n;
            if (n < SLOTS) prv[n] = p; else ctail[c] = p;
            on_list[b] = 0;
        endfunction

        function int unsigned take_head(int unsigned c);
            int unsigned b, pg;
            b = chead[c];
            pg = b / SLOTS_PER_PAGE;
            remove_block(c, b);
            if (pg_cnt[pg] > 0) pg_cnt[pg]--;
            return b;
        endfunction

        function t_outcome allocate(logic [SIZE_W-1:0] size);
            t_outcome    o;
            int unsigned lg, c, b, pg, nblk;
            bit          got;
            o = '{'0, STAT_OK, '0};
            got = 0;
            b = 0;
            if (size == 0) begin
                o.status = STAT_NULL;
                return o;
            end
            if (size > (1 << MAX_CLASS_LOG2)) begin
                o.status = STAT_RANGE;
                return o;
            end
            lg = MIN_CLASS_LOG2;
            while ((1 << lg) < size) lg++;
            c = lg - MIN_CLASS_LOG2;
            nblk = PAGE_BYTES >> lg;
            if (chead[c] < SLOTS) begin
                b = take_head(c);
                got = 1;
            end else if (fifo_cnt > 0 && nblk > 0) begin
                pg = pg_fifo[fifo_head];
                fifo_head = (fifo_head + 1) % MAX_PAGES;
                fifo_cnt--;
                for (int i = 0; i < nblk; i++) append_block(c, pg * SLOTS_PER_PAGE + (i << c));
                pg_cls[pg] = c + 1;
                pg_cnt[pg] = nblk;
                b = take_head(c);
                got = 1;
                splits++;
            end else begin
                for (int k = c + 1; k < NCLASS && !got; k++) begin
                    if (chead[k] < SLOTS) begin
                        b = take_head(k);
                        got = 1;
                    end
                end
            end
            if (!got) begin
                o.status = STAT_NOMEM;
                return o;
            end
            pg = b / SLOTS_PER_PAGE;
            o.addr = base + (b << MIN_CLASS_LOG2);
            o.bsize = (pg_cls[pg] != 0) ? SIZE_W'(1 << (pg_cls[pg] - 1 + MIN_CLASS_LOG2)) : '0;
            held.push_back(o.addr);
            return o;
        endfunction

        function t_outcome release_block(logic [ADDR_W-1:0] a);
            t_outcome    o;
            logic [31:0] off;
            int unsigned pg, c, lg, b, nblk;
            o = '{'0, STAT_IGNORED, '0};
            off = a - base;
            pg = off / PAGE_BYTES;
            if (pg_cls[pg] == 0) return o;
            c = pg_cls[pg] - 1;
            lg = c + MIN_CLASS_LOG2;
            if ((off % PAGE_BYTES) & ((1 << lg) - 1)) return o;
            b = off >> MIN_CLASS_LOG2;
            if (on_list[b]) return o;
            prepend_block(c, b);
            pg_cnt[pg]++;
            nblk = PAGE_BYTES >> lg;
            if (pg_cnt[pg] == nblk) begin
                // whole page free: pull its blocks off the list and return the page
                for (int i = 0; i < nblk; i++) begin
                    if (on_list[pg * SLOTS_PER_PAGE + (i << c)])
                        remove_block(c, pg * SLOTS_PER_PAGE + (i << c));
                end
                if (fifo_cnt < MAX_PAGES) begin
                    pg_fifo[(fifo_head + fifo_cnt) % MAX_PAGES] = pg;
                    fifo_cnt++;
                end
                pg_cls[pg] = 0;
                pg_cnt[pg] = 0;
                releases++;
            end
            foreach (held[i]) begin
                if (held[i] == a) begin
                    held.delete(i);
                    break;
                end
            end
            released.push_back(a);
            if (released.size() > 16) void'(released.pop_front());
            o.status = STAT_OK;
            o.bsize = SIZE_W'(1 << lg);
            return o;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                                logic [ADDR_W-1:0] a);
            t_outcome    o;
            bit          in_heap;
            int unsigned k;
            o = '{'0, STAT_RANGE, '0};
            in_heap = (a >= base) && (64'(a - base) < 64'(npages) * PAGE_BYTES);
            if (cmd == CMD_ALLOC) begin
                o = allocate(size);
            end else if (cmd == CMD_FREE) begin
                if (in_heap) o = release_block(a);
            end else if (cmd == CMD_QUERY) begin
                if (in_heap) begin
                    k = pg_cls[(a - base) / PAGE_BYTES];
                    o.status = STAT_OK;
                    o.bsize = (k != 0) ? SIZE_W'(1 << (k - 1 + MIN_CLASS_LOG2)) : '0;
                end
            end
            pending_q.push_back(o);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(logic [ADDR_W-1:0] a, logic [STAT_W-1:0] st, logic [SIZE_W-1:0] sz);
            t_outcome o;
            results++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result, status", st, '0);
            end else begin
                o = pending_q.pop_front();
                if (a !== o.addr) report_mismatch("result_addr", a, o.addr);
                if (st !== o.status) report_mismatch("status", st, o.status);
                if (sz !== o.bsize) report_mismatch("class_bytes", sz, o.bsize);
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata, prdata;
    bit                  quiet;
    int                  stall_left;
    int                  items;
    alloc_scoreboard     sb;

    scba_req_if req();
    scba_rsp_if rsp();

    size_class_block_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, sampled at the rising edge
    initial begin
        rsp.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready)
                sb.check_result(rsp.result_addr, rsp.status, rsp.class_bytes);
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                rsp.ready <= (stall_left == 0);
            end
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                             logic [ADDR_W-1:0] a);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req.valid      <= 1'b1;
        req.cmd        <= cmd;
        req.req_size   <= size;
        req.block_addr <= a;
        do @(posedge i_clk); while (!req.ready);
        sb.note_item(cmd, size, a);
        items++;
    endtask

    // idle the request side and let every expected result come back
    task automatic settle();
        @(negedge i_clk);
        req.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (1100) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] a, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(a, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_heap(logic [31:0] b, logic [31:0] e);
        reg_write(ADDR_BASE, b);
        reg_write(ADDR_END, e);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 6) return SIZE_W'($urandom_range(2049, 4095));
        if (r < 12) return SIZE_W'($urandom_range(257, 2048));
        if (r < 22) return SIZE_W'($urandom_range(1, 16));
        return SIZE_W'($urandom_range(17, 256));
    endfunction

    function automatic logic [ADDR_W-1:0] heap_addr();
        return sb.base + $urandom_range(0, sb.npages * PAGE_BYTES + PAGE_BYTES);
    endfunction

    task automatic free_all_held();
        while (sb.held.size() != 0) send_item(CMD_FREE, '0, sb.held[$urandom_range(0, sb.held.size() - 1)]);
    endtask

    task automatic random_items(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            quiet = ((i % 150) < 30);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_item(CMD_ALLOC, pick_size(), $urandom());
            end else if (r < 78 && sb.held.size() != 0) begin
                send_item(CMD_FREE, SIZE_W'($urandom()),
                          sb.held[$urandom_range(0, sb.held.size() - 1)]);
            end else if (r < 83 && sb.released.size() != 0) begin
                send_item(CMD_FREE, '0, sb.released[$urandom_range(0, sb.released.size() - 1)]);
            end else if (r < 88) begin
                send_item(CMD_FREE, '0, heap_addr());
            end else if (r < 94) begin
                send_item(CMD_QUERY, SIZE_W'($urandom()),
                          (sb.held.size() != 0 && r < 91) ? sb.held[0] : heap_addr());
            end else if (r < 97) begin
                send_item(logic'($urandom()) ? CMD_FREE : CMD_QUERY, '0, $urandom());
            end else begin
                send_item(CMD_BAD, SIZE_W'($urandom()), $urandom());
            end
            if ($urandom_range(0, 99) == 0) free_all_held();
        end
        free_all_held();
    endtask

    initial begin
        sb = new();
        sb.base = '0;
        sb.hend = '0;
        sb.reinit();
        items = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_ALLOC;
        req.req_size = '0;
        req.block_addr = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-page heap straight out of reset
        send_item(CMD_ALLOC, 12'd8, '0);
        send_item(CMD_QUERY, '0, '0);
        settle();

        // three-page heap: extremes, special cases, larger-class fallback
        set_heap(32'h0001_0000, 32'h0001_3000);
        send_item(CMD_ALLOC, 12'd0, '0);
        send_item(CMD_ALLOC, 12'hFFF, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 12'd2049, '0);
        send_item(CMD_QUERY, '0, 32'h0001_0000);
        send_item(CMD_FREE, '0, 32'h0001_0000);
        send_item(CMD_ALLOC, 12'd2048, '0);
        send_item(CMD_ALLOC, 12'd1000, '0);
        send_item(CMD_ALLOC, 12'd300, '0);
        send_item(CMD_ALLOC, 12'd1, '0);
        send_item(CMD_ALLOC, 12'd9, '0);
        send_item(CMD_QUERY, '0, 32'h0001_1004);
        send_item(CMD_FREE, '0, 32'h0001_0004);
        send_item(CMD_FREE, '0, 32'h0000_FFFF);
        send_item(CMD_FREE, '0, 32'h0001_3000);
        send_item(CMD_QUERY, '0, 32'h0001_2FFF);
        send_item(CMD_BAD, 12'd8, 32'h0001_0000);
        send_item(CMD_FREE, '0, sb.held[0]);
        send_item(CMD_FREE, '0, sb.released[0]);
        free_all_held();
        send_item(CMD_QUERY, '0, 32'h0001_0000);
        random_items(400);
        settle();

        // top of the address space, 15 pages
        set_heap(32'hFFFF_0000, 32'hFFFF_FFFF);
        random_items(300);
        settle();

        // huge span clamped to the page bound
        set_heap(32'h0000_0000, 32'hFFFF_FFFF);
        random_items(300);
        settle();

        // end below base, then less than one page: no pages at all
        set_heap(32'h0002_0000, 32'h0001_0000);
        random_items(60);
        settle();
        set_heap(32'hFFFF_F000, 32'hFFFF_FFFF);
        random_items(60);
        settle();

        $display("covered %0d items, %0d results, %0d page splits, %0d page releases",
                 items, sb.results, sb.splits, sb.releases);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
